[hw/rtl/rsi_pkg.sv]
`default_nettype none
package rsi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned UQ_W    = 31;
  localparam int unsigned NORM_W  = 32;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_SQUARED = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERSE_RADIUS = 3'd4;

  localparam logic [UQ_W-1:0] DIST_MAX = {UQ_W{1'b1}};

endpackage
`default_nettype wire

[hw/rtl/ray_sphere_intersect.sv]
// Ray against sphere test, one ray per beat.
// in_* : stream of rays. in_tdata from bit 0 up: origin_x, origin_y,
//   origin_z (32 b signed each), dir_x, dir_y, dir_z (18 b signed each).
// out_*: one result beat per ray, in order. out_tuser = hit;
//   out_tdata from bit 0 up: distance (31 b), normal_x, normal_y,
//   normal_z (32 b signed each). A miss gives all zeros.
// cfg_*: sphere registers, written while no ray is in flight:
//   0 center_x, 1 center_y, 2 center_z, 3 radius_squared, 4 inverse_radius.
// Throughput: one ray per cycle while the output buffer is not full. The
//   square root is resolved one root bit per pipeline stage, SQ_W stages
//   in all.
// Reset (rst_n low, synchronous) empties the pipeline and output buffer,
//   sets the center to 0 and both radius registers to 1.0.
// A stalled receiver fills a two-beat output buffer; once it is full the
//   whole pipeline holds and in_tready drops until a beat is taken.
`default_nettype none
module ray_sphere_intersect #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  wire logic [rsi_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // distance, normal_x, normal_y, normal_z
  output logic [rsi_pkg::OUT_DATA_W-1:0]         out_tdata,
  // hit
  output logic                                   out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_wen,
  input  wire logic [rsi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [rsi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned CW    = rsi_pkg::COORD_W;
  localparam int unsigned DW    = rsi_pkg::DIR_W;
  localparam int unsigned UW    = rsi_pkg::UQ_W;
  localparam int unsigned NW    = rsi_pkg::NORM_W;
  localparam int unsigned OP_W  = CW + 1;
  localparam int unsigned PD_W  = OP_W + DW;
  localparam int unsigned SUM_W = PD_W + 2;
  localparam int unsigned B_W   = SUM_W - FRAC_BITS;
  localparam int unsigned SQ1_W = 2 * OP_W;
  localparam int unsigned SSQ_W = SQ1_W + 2;
  localparam int unsigned LO_W  = (B_W + 1) / 2;
  localparam int unsigned HI_W  = B_W - LO_W;
  localparam int unsigned BSQ_W = 2 * B_W;
  localparam int unsigned R2_W  = UW + FRAC_BITS;
  localparam int unsigned MX1   = (BSQ_W > SSQ_W) ? BSQ_W : SSQ_W;
  localparam int unsigned MX2   = (MX1 > R2_W) ? MX1 : R2_W;
  localparam int unsigned DET_W = MX2 + 2;
  localparam int unsigned SQ_W  = (DET_W + 1) / 2;
  localparam int unsigned RAD_W = 2 * SQ_W;
  localparam int unsigned T_W   = ((B_W > SQ_W) ? B_W : SQ_W) + 2;
  localparam int unsigned M_W   = DW + UW + 1;
  localparam int unsigned MS_W  = M_W - FRAC_BITS;
  localparam int unsigned V_W   = ((MS_W > OP_W) ? MS_W : OP_W) + 1;
  localparam int unsigned W_W   = V_W + UW + 1;
  localparam int unsigned EPS   = ((1 << FRAC_BITS) + 500) / 1000;

  // ---------------- configuration ----------------
  logic signed [CW-1:0] ctr_r [3];
  logic [UW-1:0]        r2_r;
  logic [UW-1:0]        inv_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      r2_r     <= UW'(1) << FRAC_BITS;
      inv_r_r  <= UW'(1) << FRAC_BITS;
    end else if (cfg_wen) begin
      case (cfg_addr)
        rsi_pkg::REG_CENTER_X:       ctr_r[0] <= $signed(cfg_wdata);
        rsi_pkg::REG_CENTER_Y:       ctr_r[1] <= $signed(cfg_wdata);
        rsi_pkg::REG_CENTER_Z:       ctr_r[2] <= $signed(cfg_wdata);
        rsi_pkg::REG_RADIUS_SQUARED: r2_r     <= cfg_wdata[UW-1:0];
        rsi_pkg::REG_INVERSE_RADIUS: inv_r_r  <= cfg_wdata[UW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [1:0] cnt_r;
  logic       en;
  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  logic signed [CW-1:0] org [3];
  logic signed [DW-1:0] dir_in [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i]    = $signed(in_tdata[i*CW +: CW]);
      dir_in[i] = $signed(in_tdata[3*CW + i*DW +: DW]);
    end
  end

  // stage 1: op = center - origin
  logic                   v1_r;
  logic signed [OP_W-1:0] op1_r [3];
  logic signed [DW-1:0]   dir1_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_acc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        op1_r[i]  <= OP_W'(ctr_r[i]) - OP_W'(org[i]);
        dir1_r[i] <= dir_in[i];
      end
    end
  end

  // stage 2: lane products
  logic                    v2_r;
  logic signed [PD_W-1:0]  pd2_r [3];
  logic signed [SQ1_W-1:0] sq2_r [3];
  logic signed [OP_W-1:0]  op2_r [3];
  logic signed [DW-1:0]    dir2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd2_r[i]  <= PD_W'(op1_r[i]) * PD_W'(dir1_r[i]);
        sq2_r[i]  <= SQ1_W'(op1_r[i]) * SQ1_W'(op1_r[i]);
        op2_r[i]  <= op1_r[i];
        dir2_r[i] <= dir1_r[i];
      end
    end
  end

  // stage 3: b and |op|^2
  logic signed [SUM_W-1:0] pd_sum;
  assign pd_sum = SUM_W'(pd2_r[0]) + SUM_W'(pd2_r[1]) + SUM_W'(pd2_r[2]);

  logic                    v3_r;
  logic signed [B_W-1:0]   b3_r;
  logic signed [SSQ_W-1:0] ssq3_r;
  logic signed [OP_W-1:0]  op3_r [3];
  logic signed [DW-1:0]    dir3_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b3_r   <= B_W'(pd_sum >>> FRAC_BITS);
      ssq3_r <= SSQ_W'(sq2_r[0]) + SSQ_W'(sq2_r[1]) + SSQ_W'(sq2_r[2]);
      op3_r  <= op2_r;
      dir3_r <= dir2_r;
    end
  end

  // stage 4: b*b as three partial products
  logic [B_W-1:0]  babs;
  logic [LO_W-1:0] b_lo;
  logic [HI_W-1:0] b_hi;
  assign babs = b3_r[B_W-1] ? B_W'(-b3_r) : B_W'(b3_r);
  assign b_lo = babs[LO_W-1:0];
  assign b_hi = babs[B_W-1:LO_W];

  logic                       v4_r;
  logic [2*LO_W-1:0]          pll4_r;
  logic [HI_W+LO_W-1:0]       phl4_r;
  logic [2*HI_W-1:0]          phh4_r;
  logic signed [B_W-1:0]      b4_r;
  logic signed [SSQ_W-1:0]    ssq4_r;
  logic signed [OP_W-1:0]     op4_r [3];
  logic signed [DW-1:0]       dir4_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pll4_r <= (2*LO_W)'(b_lo) * (2*LO_W)'(b_lo);
      phl4_r <= (HI_W+LO_W)'(b_hi) * (HI_W+LO_W)'(b_lo);
      phh4_r <= (2*HI_W)'(b_hi) * (2*HI_W)'(b_hi);
      b4_r   <= b3_r;
      ssq4_r <= ssq3_r;
      op4_r  <= op3_r;
      dir4_r <= dir3_r;
    end
  end

  // stage 5: det = b*b - |op|^2 + r^2
  logic [BSQ_W-1:0]        bsq;
  logic signed [DET_W-1:0] det;
  assign bsq = (BSQ_W'(phh4_r) << (2*LO_W)) + (BSQ_W'(phl4_r) << (LO_W+1))
             + BSQ_W'(pll4_r);
  assign det = $signed(DET_W'(bsq)) - DET_W'(ssq4_r)
             + $signed(DET_W'(r2_r) << FRAC_BITS);

  // square root pipeline, index 0 is the det stage
  logic                    sv_r   [SQ_W+1];
  logic                    neg_r  [SQ_W+1];
  logic [RAD_W-1:0]        rem_r  [SQ_W+1];
  logic [SQ_W-1:0]         root_r [SQ_W+1];
  logic signed [B_W-1:0]   sb_r   [SQ_W+1];
  logic signed [OP_W-1:0]  sop_r  [SQ_W+1][3];
  logic signed [DW-1:0]    sdir_r [SQ_W+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (en) sv_r[0] <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= det[DET_W-1];
      rem_r[0]  <= det[DET_W-1] ? '0 : RAD_W'(unsigned'(det));
      root_r[0] <= '0;
      sb_r[0]   <= b4_r;
      sop_r[0]  <= op4_r;
      sdir_r[0] <= dir4_r;
    end
  end

  for (genvar k = 1; k <= SQ_W; k++) begin : g_sqrt
    localparam int unsigned BIT = SQ_W - k;
    logic [RAD_W-1:0] trial;
    logic             take;
    assign trial = (RAD_W'(root_r[k-1]) << (BIT + 1)) | (RAD_W'(1) << (2*BIT));
    assign take  = (rem_r[k-1] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k] <= 1'b0;
      else if (en) sv_r[k] <= sv_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? rem_r[k-1] - trial : rem_r[k-1];
        root_r[k] <= take ? root_r[k-1] | (SQ_W'(1) << BIT) : root_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        sb_r[k]   <= sb_r[k-1];
        sop_r[k]  <= sop_r[k-1];
        sdir_r[k] <= sdir_r[k-1];
      end
    end
  end

  // near root, epsilon test, distance clamp
  logic signed [T_W-1:0] t_near;
  logic                  t_hit;
  assign t_near = T_W'(sb_r[SQ_W]) - $signed(T_W'(root_r[SQ_W]));
  assign t_hit  = !neg_r[SQ_W] && (t_near > $signed(T_W'(EPS)));

  logic                   vt_r;
  logic                   hitt_r;
  logic [UW-1:0]          distt_r;
  logic signed [OP_W-1:0] opt_r [3];
  logic signed [DW-1:0]   dirt_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) vt_r <= 1'b0;
    else if (en) vt_r <= sv_r[SQ_W];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hitt_r <= t_hit;
      if (!t_hit) distt_r <= '0;
      else if (t_near > $signed(T_W'(rsi_pkg::DIST_MAX))) distt_r <= rsi_pkg::DIST_MAX;
      else distt_r <= t_near[UW-1:0];
      opt_r  <= sop_r[SQ_W];
      dirt_r <= sdir_r[SQ_W];
    end
  end

  // normal stage 1: dir * distance
  logic                   vn1_r;
  logic                   hitn1_r;
  logic [UW-1:0]          distn1_r;
  logic signed [M_W-1:0]  m_r [3];
  logic signed [OP_W-1:0] opn1_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) vn1_r <= 1'b0;
    else if (en) vn1_r <= vt_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        m_r[i] <= M_W'(dirt_r[i]) * $signed(M_W'(distt_r));
      hitn1_r  <= hitt_r;
      distn1_r <= distt_r;
      opn1_r   <= opt_r;
    end
  end

  // normal stage 2: hit point - center
  logic                  vn2_r;
  logic                  hitn2_r;
  logic [UW-1:0]         distn2_r;
  logic signed [V_W-1:0] vv_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) vn2_r <= 1'b0;
    else if (en) vn2_r <= vn1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        vv_r[i] <= V_W'(m_r[i] >>> FRAC_BITS) - V_W'(opn1_r[i]);
      hitn2_r  <= hitn1_r;
      distn2_r <= distn1_r;
    end
  end

  // normal stage 3: scale by 1/r
  logic                  vn3_r;
  logic                  hitn3_r;
  logic [UW-1:0]         distn3_r;
  logic signed [W_W-1:0] ww_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) vn3_r <= 1'b0;
    else if (en) vn3_r <= vn2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        ww_r[i] <= W_W'(vv_r[i]) * $signed(W_W'(inv_r_r));
      hitn3_r  <= hitn2_r;
      distn3_r <= distn2_r;
    end
  end

  function automatic logic [NW-1:0] sat_norm(input logic signed [W_W-1:0] w);
    logic signed [W_W-1:0] s;
    s = w >>> FRAC_BITS;
    if (s > $signed(W_W'({1'b0, {(NW-1){1'b1}}})))
      sat_norm = {1'b0, {(NW-1){1'b1}}};
    else if (s < -$signed(W_W'({1'b1, {(NW-1){1'b0}}})))
      sat_norm = {1'b1, {(NW-1){1'b0}}};
    else
      sat_norm = s[NW-1:0];
  endfunction

  logic [rsi_pkg::OUT_DATA_W-1:0] res_data;
  always_comb begin
    res_data = '0;
    if (hitn3_r) begin
      res_data[UW-1:0] = distn3_r;
      for (int i = 0; i < 3; i++)
        res_data[UW + i*NW +: NW] = sat_norm(ww_r[i]);
    end
  end

  // ---------------- output buffer, two beats ----------------
  logic [rsi_pkg::OUT_DATA_W-1:0] fdata_r [2];
  logic                           fhit_r  [2];
  logic                           wp_r, rp_r;
  logic                           push, pop;

  assign push = en && vn3_r;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fdata_r[wp_r] <= res_data;
      fhit_r[wp_r]  <= hitn3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = fdata_r[rp_r];
  assign out_tuser  = fhit_r[rp_r];

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss beat carries nonzero payload");

  a_hit_eps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[UW-1:0] > UW'(EPS))
    else $error("hit with distance not above epsilon");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overflow");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !v1_r && !vn3_r)
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

[sim/tb_ray_sphere_intersect.sv]
`default_nettype none
module tb_ray_sphere_intersect;

  localparam int FB = 16;
  localparam longint EPS_Q = ((64'sd1 <<< FB) + 500) / 1000;
  localparam int LATENCY = 60;

  typedef struct {
    logic        hit;
    logic [30:0] distance;
    logic [31:0] nx, ny, nz;
  } hit_info_t;

  class sphere_scoreboard;
    longint cx, cy, cz;
    longint r2, inv_r;
    hit_info_t pending[$];
    int errors;

    function new();
      cx = 0; cy = 0; cz = 0;
      r2 = 64'd1 << FB; inv_r = 64'd1 << FB;
      errors = 0;
    endfunction

    function void set_reg(logic [rsi_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
      case (idx)
        rsi_pkg::REG_CENTER_X:       cx = longint'($signed(val));
        rsi_pkg::REG_CENTER_Y:       cy = longint'($signed(val));
        rsi_pkg::REG_CENTER_Z:       cz = longint'($signed(val));
        rsi_pkg::REG_RADIUS_SQUARED: r2 = longint'(val[30:0]);
        rsi_pkg::REG_INVERSE_RADIUS: inv_r = longint'(val[30:0]);
        default: ;
      endcase
    endfunction

    static function logic [31:0] sat32(logic signed [127:0] v);
      if (v > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (v < -128'sh80000000) return 32'h80000000;
      return v[31:0];
    endfunction

    static function logic [63:0] root_floor(logic [127:0] d);
      logic [63:0] res, c;
      res = 0;
      for (int bt = 47; bt >= 0; bt--) begin
        c = res | (64'd1 << bt);
        if ({64'd0, c} * {64'd0, c} <= d) res = c;
      end
      return res;
    endfunction

    function void note_ray(logic [rsi_pkg::IN_DATA_W-1:0] d);
      longint op[3], dr[3], b, t, dclamp;
      logic signed [127:0] det, v, n;
      hit_info_t e;
      longint ctr[3];
      ctr[0] = cx; ctr[1] = cy; ctr[2] = cz;
      e = '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0};
      for (int i = 0; i < 3; i++) begin
        op[i] = ctr[i] - longint'($signed(d[32*i +: 32]));
        dr[i] = longint'($signed(d[96 + 18*i +: 18]));
      end
      b = (op[0]*dr[0] + op[1]*dr[1] + op[2]*dr[2]) >>> FB;
      det = 128'(b) * 128'(b);
      for (int i = 0; i < 3; i++) det = det - 128'(op[i]) * 128'(op[i]);
      det = det + 128'(r2 <<< FB);
      if (det >= 0) begin
        t = b - longint'(root_floor(det));
        if (t > EPS_Q) begin
          dclamp = (t > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : t;
          e.hit = 1'b1;
          e.distance = dclamp[30:0];
          for (int i = 0; i < 3; i++) begin
            v = 128'((dr[i] * dclamp) >>> FB) - 128'(op[i]);
            n = (v * 128'(inv_r)) >>> FB;
            if (i == 0) e.nx = sat32(n);
            else if (i == 1) e.ny = sat32(n);
            else e.nz = sat32(n);
          end
        end
      end
      pending.push_back(e);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      errors++;
    endtask

    task automatic check_result(logic hit, logic [rsi_pkg::OUT_DATA_W-1:0] d);
      hit_info_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", {63'd0, hit}, 64'd0);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report("hit", hit, e.hit);
      if (d[30:0] !== e.distance) report("distance", d[30:0], e.distance);
      if (d[62:31] !== e.nx) report("normal_x", d[62:31], e.nx);
      if (d[94:63] !== e.ny) report("normal_y", d[94:63], e.ny);
      if (d[126:95] !== e.nz) report("normal_z", d[126:95], e.nz);
      if (d[127] !== 1'b0) report("pad", d[127], 0);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic [rsi_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 0, in_tready;
  logic [rsi_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser, out_tvalid;
  logic out_tready = 0;
  logic cfg_wen = 0;
  logic [rsi_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int idle_pct = 23;
  bit hold_off = 0;
  sphere_scoreboard sb = new();

  ray_sphere_intersect dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= rst_n && !hold_off && ($urandom_range(99) >= idle_pct);
  end

  task automatic write_reg(logic [rsi_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_wen <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_ray(logic [31:0] ox, oy, oz, logic [17:0] dx, dy, dz);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tdata <= {dz, dy, dx, oz, oy, ox};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_ray({dz, dy, dx, oz, oy, ox});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [17:0] rand_dir();
    case ($urandom_range(5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'($urandom);
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(int span);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(2*span)) - span);
    endcase
  endfunction

  // mostly rays aimed at the sphere from outside, with random scatter
  task automatic random_phase(int n, int span);
    logic [31:0] ox, oy, oz;
    logic [17:0] dx, dy, dz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        dx = rand_dir(); dy = rand_dir(); dz = rand_dir();
        ox = 32'(sb.cx - ((longint'($signed(dx)) * span) >>> FB)
             + $signed($urandom_range(131072)) - 65536);
        oy = 32'(sb.cy - ((longint'($signed(dy)) * span) >>> FB)
             + $signed($urandom_range(131072)) - 65536);
        oz = 32'(sb.cz - ((longint'($signed(dz)) * span) >>> FB));
      end else begin
        ox = rand_coord(span); oy = rand_coord(span); oz = rand_coord(span);
        dx = rand_dir(); dy = rand_dir(); dz = 18'($urandom);
      end
      send_ray(ox, oy, oz, dx, dy, dz);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed, reset sphere: unit radius at origin
    send_ray(32'hFFFB0000, 0, 0, 18'sd65536, 0, 0);   // hit at 4.0
    send_ray(32'hFFFB0000, 0, 0, -18'sd65536, 0, 0);  // pointing away
    send_ray(0, 0, 0, 18'sd65536, 0, 0);              // inside sphere
    send_ray(32'hFFFF0000, 0, 0, 18'sd65536, 0, 0);   // on surface, t near 0
    send_ray(32'hFFFEFFA0, 0, 0, 18'sd65536, 0, 0);   // t just above eps
    send_ray(32'hFFFB0000, 32'h00010000, 0, 18'sd65536, 0, 0); // grazing
    send_ray(32'hFFFB0000, 32'h00020000, 0, 18'sd65536, 0, 0); // miss
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, 18'sd65536, 18'sd65536,
             18'sd65536);
    send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -18'sd65536, -18'sd65536,
             -18'sd65536);
    send_ray(32'hFFFB0000, 0, 0, 18'h1FFFF, 18'h20000, 18'h3FFFF); // non-unit
    send_ray(0, 0, 32'hFFF00000, 0, 0, 18'sd65536);
    send_ray(0, 32'h00100000, 0, 0, -18'sd65536, 0);
    drain();
    // huge sphere: distance and normal saturation
    write_reg(rsi_pkg::REG_CENTER_X, 32'h7FFFFFFF);
    write_reg(rsi_pkg::REG_CENTER_Y, 32'h80000000);
    write_reg(rsi_pkg::REG_CENTER_Z, 0);
    write_reg(rsi_pkg::REG_RADIUS_SQUARED, 32'h7FFFFFFF);
    write_reg(rsi_pkg::REG_INVERSE_RADIUS, 32'h7FFFFFFF);
    write_reg(3'd7, 32'h12345678);   // out-of-range index, ignored
    send_ray(32'h80000000, 32'h7FFFFFFF, 0, 18'sd46341, -18'sd46341, 0);
    send_ray(32'h80000000, 0, 0, 18'sd65536, 0, 0);
    send_ray(0, 0, 32'h80000000, 0, 0, 18'sd65536);
    random_phase(100, 32'h40000000);
    drain();
    // zero radius, zero inverse radius
    write_reg(rsi_pkg::REG_CENTER_X, 0);
    write_reg(rsi_pkg::REG_CENTER_Y, 0);
    write_reg(rsi_pkg::REG_RADIUS_SQUARED, 0);
    write_reg(rsi_pkg::REG_INVERSE_RADIUS, 0);
    random_phase(100, 32'h00080000);
    drain();
    // mid-size sphere, backpressure burst
    write_reg(rsi_pkg::REG_CENTER_X, 32'h00030000);
    write_reg(rsi_pkg::REG_CENTER_Y, 32'hFFFE0000);
    write_reg(rsi_pkg::REG_CENTER_Z, 32'h00108000);
    write_reg(rsi_pkg::REG_RADIUS_SQUARED, 32'h00040000);
    write_reg(rsi_pkg::REG_INVERSE_RADIUS, 32'h00008000);
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      random_phase(150, 32'h00100000);
    join
    drain();
    idle_pct = 0;
    random_phase(300, 32'h00100000);
    idle_pct = 23;
    random_phase(400, 32'h00100000);
    drain();
    write_reg(rsi_pkg::REG_CENTER_X, $urandom);
    write_reg(rsi_pkg::REG_CENTER_Y, $urandom);
    write_reg(rsi_pkg::REG_CENTER_Z, $urandom);
    write_reg(rsi_pkg::REG_RADIUS_SQUARED, $urandom);
    write_reg(rsi_pkg::REG_INVERSE_RADIUS, $urandom_range(32'h00100000));
    random_phase(480, 32'h01000000);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
